// ----- rtl/core/led_timed_flash_controller_unit_defines.svh -----
// Assertion macros shared by the LED controller RTL.
`ifndef LED_TIMED_FLASH_CONTROLLER_UNIT_DEFINES_SVH
`define LED_TIMED_FLASH_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LTFC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LTFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ltfc_pkg.sv -----
package ltfc_pkg;

  // Field widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned IDX_W    = 1;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned TOTAL_W  = 8;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned LEVELS_W = 2;
  localparam int unsigned HP_W     = 8;
  localparam int unsigned BUDGET_W = 10;
  localparam int unsigned MODE_W   = 2;

  // Default LED count
  localparam int unsigned LTFC_NUM_LEDS = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_OFF   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ON    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TIMED = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FLASH = 3'd4;

  // LED mode codes
  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLASH = 2'd2;

endpackage

// ----- rtl/core/ltfc_in_if.sv -----
interface ltfc_in_if;
  import ltfc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [IDX_W-1:0]     led_index;
  logic [TIME_W-1:0]    time_value;
  logic [TOTAL_W-1:0]   flash_total_time;
  logic [COUNT_W-1:0]   flash_count;

  modport source (
    output valid, cmd, led_index, time_value, flash_total_time, flash_count,
    input  ready
  );

  modport sink (
    input  valid, cmd, led_index, time_value, flash_total_time, flash_count,
    output ready
  );
endinterface

// ----- rtl/core/ltfc_out_if.sv -----
interface ltfc_out_if;
  import ltfc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [LEVELS_W-1:0]  led_levels;

  modport source (
    output valid, led_levels,
    input  ready
  );

  modport sink (
    input  valid, led_levels,
    output ready
  );
endinterface

// ----- rtl/core/led_timed_flash_controller_unit.sv -----
// Latency: a result word is valid in the cycle after its command word is accepted.
// Throughput: one command word per cycle while the result side takes its words;
// the single output register stalls the input only when it is full and not taken.
// Reset (rst_ni low, asynchronous): every LED off and low, all counters zero,
// no result pending.
`include "led_timed_flash_controller_unit_defines.svh"

module led_timed_flash_controller_unit #(
  parameter int unsigned NUM_LEDS = ltfc_pkg::LTFC_NUM_LEDS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ltfc_in_if.sink            in_i,
  ltfc_out_if.source         out_o
);
  import ltfc_pkg::*;

  // Per-LED state
  logic [MODE_W-1:0]          mode_q     [NUM_LEDS];
  logic [MODE_W-1:0]          mode_d     [NUM_LEDS];
  logic                       level_q    [NUM_LEDS];
  logic                       level_d    [NUM_LEDS];
  logic [TIME_W-1:0]          cnt_q      [NUM_LEDS];
  logic [TIME_W-1:0]          cnt_d      [NUM_LEDS];
  logic                       timed_q    [NUM_LEDS];
  logic                       timed_d    [NUM_LEDS];
  logic [HP_W-1:0]            hp_q       [NUM_LEDS];
  logic [HP_W-1:0]            hp_d       [NUM_LEDS];
  logic [COUNT_W-1:0]         lim_q      [NUM_LEDS];
  logic [COUNT_W-1:0]         lim_d      [NUM_LEDS];
  logic [COUNT_W-1:0]         done_q     [NUM_LEDS];
  logic [COUNT_W-1:0]         done_d     [NUM_LEDS];
  logic signed [BUDGET_W-1:0] budget_q   [NUM_LEDS];
  logic signed [BUDGET_W-1:0] budget_d   [NUM_LEDS];
  logic                       bud_en_q   [NUM_LEDS];
  logic                       bud_en_d   [NUM_LEDS];

  // Result register
  logic                       out_valid_q;
  logic [LEVELS_W-1:0]        levels_q;
  logic [LEVELS_W-1:0]        levels_d;
  logic [LEVELS_W-1:0]        levels_now;

  logic                       accept;

  // Take a word whenever the result register is empty or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Next state of every LED, updated in parallel
  always_comb begin
    logic                       tgt;
    logic                       stop;
    logic [COUNT_W-1:0]         done_inc;
    logic signed [BUDGET_W-1:0] bud_sub;
    for (int i = 0; i < NUM_LEDS; i++) begin
      mode_d[i]   = mode_q[i];
      level_d[i]  = level_q[i];
      cnt_d[i]    = cnt_q[i];
      timed_d[i]  = timed_q[i];
      hp_d[i]     = hp_q[i];
      lim_d[i]    = lim_q[i];
      done_d[i]   = done_q[i];
      budget_d[i] = budget_q[i];
      bud_en_d[i] = bud_en_q[i];

      tgt      = (i < 2) && (in_i.led_index == IDX_W'(i));
      stop     = 1'b0;
      done_inc = done_q[i] + COUNT_W'(1);
      bud_sub  = budget_q[i] - $signed({{(BUDGET_W-HP_W){1'b0}}, hp_q[i]});

      if (in_i.cmd == CMD_TICK) begin
        if (mode_q[i] == MODE_ON) begin
          level_d[i] = 1'b1;
          if (timed_q[i]) begin
            if (cnt_q[i] != '0) begin
              cnt_d[i] = cnt_q[i] - TIME_W'(1);
            end else begin
              mode_d[i]  = MODE_OFF;
              level_d[i] = 1'b0;
            end
          end
        end else if (mode_q[i] == MODE_FLASH) begin
          if (cnt_q[i] != '0) begin
            cnt_d[i] = cnt_q[i] - TIME_W'(1);
          end else begin
            // Half-period elapsed: count the toggle when a limit is set and spend the budget when enabled
            if (lim_q[i] != '0) begin
              done_d[i] = done_inc;
              if (done_inc == lim_q[i]) stop = 1'b1;
            end
            if (bud_en_q[i]) begin
              budget_d[i] = bud_sub;
              if (bud_sub <= 0) stop = 1'b1;
            end
            if (stop) begin
              mode_d[i]  = MODE_OFF;
              level_d[i] = 1'b0;
              cnt_d[i]   = '0;
              lim_d[i]   = '0;
              done_d[i]  = '0;
            end else begin
              level_d[i] = !level_q[i];
              cnt_d[i]   = {{(TIME_W-HP_W){1'b0}}, hp_q[i]};
            end
          end
        end else begin
          mode_d[i]  = MODE_OFF;
          level_d[i] = 1'b0;
        end
      end else if (tgt) begin
        if (in_i.cmd == CMD_OFF || in_i.cmd == CMD_ON || in_i.cmd == CMD_TIMED) begin
          mode_d[i]  = (in_i.cmd == CMD_OFF) ? MODE_OFF : MODE_ON;
          level_d[i] = (in_i.cmd != CMD_OFF);
          timed_d[i] = (in_i.cmd == CMD_TIMED);
          cnt_d[i]   = (in_i.cmd == CMD_TIMED) ? in_i.time_value : '0;
          lim_d[i]   = '0;
          done_d[i]  = '0;
        end else if (in_i.cmd == CMD_FLASH) begin
          mode_d[i]   = MODE_FLASH;
          hp_d[i]     = in_i.time_value[HP_W-1:0];
          cnt_d[i]    = {{(TIME_W-HP_W){1'b0}}, in_i.time_value[HP_W-1:0]};
          budget_d[i] = $signed({{(BUDGET_W-TOTAL_W){1'b0}}, in_i.flash_total_time});
          bud_en_d[i] = (in_i.flash_total_time != '0);
          lim_d[i]    = in_i.flash_count;
          done_d[i]   = '0;
        end
      end
    end
  end

  // Gather the visible levels, before and after the step
  always_comb begin
    for (int b = 0; b < LEVELS_W; b++) begin
      if (b < NUM_LEDS) begin
        levels_d[b]   = level_d[b];
        levels_now[b] = level_q[b];
      end else begin
        levels_d[b]   = 1'b0;
        levels_now[b] = 1'b0;
      end
    end
  end

  // Advance the LED state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        mode_q[i]   <= MODE_OFF;
        level_q[i]  <= 1'b0;
        cnt_q[i]    <= '0;
        timed_q[i]  <= 1'b0;
        hp_q[i]     <= '0;
        lim_q[i]    <= '0;
        done_q[i]   <= '0;
        budget_q[i] <= '0;
        bud_en_q[i] <= 1'b0;
      end
    end else if (accept) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        mode_q[i]   <= mode_d[i];
        level_q[i]  <= level_d[i];
        cnt_q[i]    <= cnt_d[i];
        timed_q[i]  <= timed_d[i];
        hp_q[i]     <= hp_d[i];
        lim_q[i]    <= lim_d[i];
        done_q[i]   <= done_d[i];
        budget_q[i] <= budget_d[i];
        bud_en_q[i] <= bud_en_d[i];
      end
    end
  end

  // Hold the result word until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) levels_q <= levels_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.led_levels = levels_q;

  // Checks
  `LTFC_ASSERT_NEXT(a_accept_gives_result, clk_i, rst_ni, accept, out_valid_q,
    "accepted word produced no result")
  `LTFC_ASSERT_SAME(a_result_tracks_state, clk_i, rst_ni, out_valid_q,
    levels_q == levels_now, "pending result differs from LED levels")
  `LTFC_ASSERT_SAME(a_off_is_dark, clk_i, rst_ni, mode_q[0] == MODE_OFF,
    level_q[0] == 1'b0, "LED in off mode drives high")

endmodule
